/* rtl/mm_pkg.sv */
// ---------------------------------------------------------------------------
// mm_pkg: shared types and constants for the matrix multiply block
// operation codes, register indexes, field widths and the load bus
// ---------------------------------------------------------------------------
package mm_pkg;

   localparam int DEFAULT_MAX_DIM = 8;

   localparam int VAL_W = 16;   // Q8.8 element
   localparam int PROD_W = 32;  // Q16.16 product
   localparam int SUM_W = 35;   // Q19.16 dot product
   localparam int POS_W = 3;    // row and col fields
   localparam int CFG_W = 4;    // shape registers
   localparam int CSR_IDX_W = 2;

   typedef enum logic [1:0] {
      OP_LOAD_A = 2'd0,
      OP_LOAD_B = 2'd1,
      OP_RUN    = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS_A     = 2'd0,
      CSR_INNER_SIZE = 2'd1,
      CSR_COLS_B     = 2'd2
   } csr_index_type;

   localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

   // element load broadcast to every cell
   typedef struct packed {
      logic                    a_we;
      logic                    b_we;
      logic [POS_W-1:0]        row;
      logic [POS_W-1:0]        col;
      logic signed [VAL_W-1:0] value;
   } load_type;

endpackage

/* rtl/matrix_multiply.sv */
// ---------------------------------------------------------------------------
// matrix_multiply: fixed-point matrix product through a chain of MAC cells
//
//  channel  direction  fields
//  req_     in         tuser: operation; tdata: row, col, value
//  rsp_     out        tdata: out_row, out_col, product_sum; tlast: last
//  csr_     in         index: register, data: shape value
//
// load items are taken whenever no run is busy; a run item gives one result per
// cycle while the chain is not frozen, once the cell chain has filled, and no
// item is taken until the final result of the run is taken.
// rsp_tready low while a result is shown freezes the whole chain and the sequencer.
// reset clears the shape registers to 8 and the control state; stored
// elements are undefined until loaded.
// ---------------------------------------------------------------------------
module matrix_multiply
   import mm_pkg::*;
#(
   parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [23:0]          req_tdata,   // row, col, value, zero pad
   input  logic [1:0]           req_tuser,   // operation
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [47:0]          rsp_tdata,   // out_row, out_col, product_sum, zero pad
   output logic                 rsp_tlast,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   localparam int IDX_W = $clog2(MAX_DIM);
   localparam int DIM_W = $clog2(MAX_DIM+1);

   logic [CFG_W-1:0] rows_a_ff, inner_size_ff, cols_b_ff;
   logic [DIM_W-1:0] nr, nk, nc;
   logic             busy_ff, busy_in;
   logic             req_accept, rsp_accept, start, advance, in_range;
   load_type         load;
   logic [POS_W-1:0] req_row, req_col;

   logic                    tv [MAX_DIM+1];
   logic [IDX_W-1:0]        ti [MAX_DIM+1];
   logic [IDX_W-1:0]        tj [MAX_DIM+1];
   logic                    tl [MAX_DIM+1];
   logic signed [SUM_W-1:0] ts [MAX_DIM+1];

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff <= CFG_RESET;
         inner_size_ff <= CFG_RESET;
         cols_b_ff <= CFG_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ROWS_A:     rows_a_ff <= csr_data;
            CSR_INNER_SIZE: inner_size_ff <= csr_data;
            CSR_COLS_B:     cols_b_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      nr = clamp_dim(rows_a_ff);
      nk = clamp_dim(inner_size_ff);
      nc = clamp_dim(cols_b_ff);
   end

   assign req_tready = !busy_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign advance = !rsp_tvalid || rsp_tready;
   assign start = req_accept && (req_tuser == OP_RUN);

   assign req_row = req_tdata[2:0];
   assign req_col = req_tdata[5:3];

   always_comb begin
      in_range = (32'(req_row) < MAX_DIM) && (32'(req_col) < MAX_DIM);
      load.a_we = req_accept && in_range && (req_tuser == OP_LOAD_A);
      load.b_we = req_accept && in_range && (req_tuser == OP_LOAD_B);
      load.row = req_row;
      load.col = req_col;
      load.value = req_tdata[21:6];
   end

   // busy from run item until its final result is taken
   always_comb begin
      busy_in = busy_ff;
      priority if (start) begin
         busy_in = 1'b1;
      end else if (rsp_accept && rsp_tlast) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   mm_issue #(.MAX_DIM(MAX_DIM)) u_issue (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .advance   (advance),
      .nr        (nr),
      .nc        (nc),
      .tok_valid (tv[0]),
      .tok_i     (ti[0]),
      .tok_j     (tj[0]),
      .tok_last  (tl[0])
   );
   assign ts[0] = '0;

   for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
      mm_cell #(.MAX_DIM(MAX_DIM), .K(k)) u_cell (
         .clock         (clock),
         .reset         (reset),
         .load          (load),
         .advance       (advance),
         .nk            (nk),
         .tok_valid_in  (tv[k]),
         .tok_i_in      (ti[k]),
         .tok_j_in      (tj[k]),
         .tok_last_in   (tl[k]),
         .tok_sum_in    (ts[k]),
         .tok_valid_out (tv[k+1]),
         .tok_i_out     (ti[k+1]),
         .tok_j_out     (tj[k+1]),
         .tok_last_out  (tl[k+1]),
         .tok_sum_out   (ts[k+1])
      );
   end

   assign rsp_tvalid = tv[MAX_DIM];
   assign rsp_tlast = tl[MAX_DIM];
   assign rsp_tdata = {7'd0, ts[MAX_DIM], 3'(tj[MAX_DIM]), 3'(ti[MAX_DIM])};

`ifndef SYNTH
   a_rsp_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> busy_ff)
      else $error("result shown outside a run");
   a_issue_in_run: assert property (@(posedge clock) disable iff (reset)
      tv[0] |-> busy_ff)
      else $error("sequencer active outside a run");
   a_issue_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && rsp_tlast) |-> !tv[0])
      else $error("final result left before sequencer finished");
   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      start |=> (tv[0] && busy_ff))
      else $error("run item did not start the sequencer");
`endif

endmodule

/* rtl/mm_cell.sv */
// ---------------------------------------------------------------------------
// mm_cell: one multiply-accumulate cell of the dot-product chain
// holds column K of A and row K of B; when K is below the inner size, adds A[i][K]*B[K][j] to the passing sum
// ---------------------------------------------------------------------------
module mm_cell
   import mm_pkg::*;
#(
   parameter int MAX_DIM = DEFAULT_MAX_DIM,
   parameter int K = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  load_type                        load,
   input  logic                            advance,
   input  logic [$clog2(MAX_DIM+1)-1:0]    nk,
   input  logic                            tok_valid_in,
   input  logic [$clog2(MAX_DIM)-1:0]      tok_i_in,
   input  logic [$clog2(MAX_DIM)-1:0]      tok_j_in,
   input  logic                            tok_last_in,
   input  logic signed [SUM_W-1:0]         tok_sum_in,
   output logic                            tok_valid_out,
   output logic [$clog2(MAX_DIM)-1:0]      tok_i_out,
   output logic [$clog2(MAX_DIM)-1:0]      tok_j_out,
   output logic                            tok_last_out,
   output logic signed [SUM_W-1:0]         tok_sum_out
);

   localparam int IDX_W = $clog2(MAX_DIM);

   logic signed [VAL_W-1:0] a_col_ff [MAX_DIM];
   logic signed [VAL_W-1:0] b_row_ff [MAX_DIM];

   logic                    valid_ff, valid_in;
   logic [IDX_W-1:0]        i_ff, j_ff;
   logic                    last_ff;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [PROD_W-1:0] prod;
   logic                    active;

   always_ff @(posedge clock) begin
      if (load.a_we && (32'(load.col) == K)) begin
         a_col_ff[IDX_W'(load.row)] <= load.value;
      end
      if (load.b_we && (32'(load.row) == K)) begin
         b_row_ff[IDX_W'(load.col)] <= load.value;
      end
   end

   always_comb begin
      active = (32'(nk) > K);
      prod = a_col_ff[tok_i_in] * b_row_ff[tok_j_in];
      sum_in = active ? (tok_sum_in + SUM_W'(prod)) : tok_sum_in;
      valid_in = advance ? tok_valid_in : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         i_ff <= tok_i_in;
         j_ff <= tok_j_in;
         last_ff <= tok_last_in;
         sum_ff <= sum_in;
      end
   end

   assign tok_valid_out = valid_ff;
   assign tok_i_out = i_ff;
   assign tok_j_out = j_ff;
   assign tok_last_out = last_ff;
   assign tok_sum_out = sum_ff;

endmodule

/* rtl/mm_issue.sv */
// ---------------------------------------------------------------------------
// mm_issue: result index sequencer
// walks the result elements in row-major order, one per advancing cycle
// ---------------------------------------------------------------------------
module mm_issue
   import mm_pkg::*;
#(
   parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            advance,
   input  logic [$clog2(MAX_DIM+1)-1:0]    nr,
   input  logic [$clog2(MAX_DIM+1)-1:0]    nc,
   output logic                            tok_valid,
   output logic [$clog2(MAX_DIM)-1:0]      tok_i,
   output logic [$clog2(MAX_DIM)-1:0]      tok_j,
   output logic                            tok_last
);

   localparam int IDX_W = $clog2(MAX_DIM);
   localparam int DIM_W = $clog2(MAX_DIM+1);

   logic             issuing_ff, issuing_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in;
   logic             row_end, col_end;

   always_comb begin
      col_end = ((DIM_W'(j_ff) + DIM_W'(1)) == nc);
      row_end = ((DIM_W'(i_ff) + DIM_W'(1)) == nr);
      issuing_in = issuing_ff;
      i_in = i_ff;
      j_in = j_ff;
      priority if (start) begin
         issuing_in = 1'b1;
         i_in = '0;
         j_in = '0;
      end else if (issuing_ff && advance) begin
         if (col_end) begin
            j_in = '0;
            i_in = i_ff + IDX_W'(1);
            if (row_end) begin
               issuing_in = 1'b0;
            end
         end else begin
            j_in = j_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff <= 1'b0;
         i_ff <= '0;
         j_ff <= '0;
      end else begin
         issuing_ff <= issuing_in;
         i_ff <= i_in;
         j_ff <= j_in;
      end
   end

   assign tok_valid = issuing_ff;
   assign tok_i = i_ff;
   assign tok_j = j_ff;
   assign tok_last = row_end && col_end;

endmodule

/* tb/sv/tb_matrix_multiply.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_matrix_multiply: self-checking bench for the matrix multiply block
// loads A and B elements, runs products under several shape settings and
// compares every result element with a local model of the stores and sums
// ---------------------------------------------------------------------------
module tb_matrix_multiply;
   import mm_pkg::*;

   localparam int DIM = DEFAULT_MAX_DIM;

   // operation code with no meaning, must give no result
   localparam logic [1:0] OP_NONE = 2'd3;

   typedef struct {
      logic [POS_W-1:0]       orow;
      logic [POS_W-1:0]       ocol;
      logic [SUM_W-1:0]       sum;
      logic                   lst;
   } element_type;

   typedef struct {
      op_type           op;
      logic [2:0]       row;
      logic [2:0]       col;
      logic [15:0]      value;
      bit               typed;   // expected sum typed in below
      logic [SUM_W-1:0] sum;
   } vector_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_data = '0;

   logic [15:0] a_mem [DIM*DIM];
   logic [15:0] b_mem [DIM*DIM];
   logic [CFG_W-1:0] n_rows = CFG_RESET, n_inner = CFG_RESET, n_cols = CFG_RESET;
   element_type pending_elems[$];
   int errors = 0;
   int elems_seen = 0;
   int runs_done = 0;
   bit typed_pending = 0;
   logic [SUM_W-1:0] typed_sum;

   matrix_multiply dut (.*);

   always #10 clock = ~clock;

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic int eff(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > DIM) return DIM;
      return int'(v);
   endfunction

   // store loads and the product of a run
   task automatic predict_item(op_type op, logic [2:0] r, logic [2:0] c, logic [15:0] v);
      int nr, nk, nc;
      logic signed [SUM_W-1:0] acc;
      element_type e;
      nr = eff(n_rows);
      nk = eff(n_inner);
      nc = eff(n_cols);
      if (op == OP_LOAD_A) begin
         a_mem[r*DIM+c] = v;
      end else if (op == OP_LOAD_B) begin
         b_mem[r*DIM+c] = v;
      end else if (op == OP_RUN) begin
         runs_done++;
         for (int i = 0; i < nr; i++)
            for (int j = 0; j < nc; j++) begin
               acc = '0;
               for (int k = 0; k < nk; k++)
                  acc += $signed(a_mem[i*DIM+k]) * $signed(b_mem[k*DIM+j]);
               e.orow = POS_W'(i);
               e.ocol = POS_W'(j);
               e.sum = acc;
               e.lst = (i == nr-1 && j == nc-1);
               pending_elems.push_back(e);
            end
      end
   endtask

   always @(posedge clock) begin
      element_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         elems_seen++;
         if (pending_elems.size() == 0) begin
            report("unexpected item", rsp_tdata, 0);
         end else begin
            e = pending_elems.pop_front();
            if (rsp_tdata[2:0] !== e.orow) report("out_row", rsp_tdata[2:0], e.orow);
            if (rsp_tdata[5:3] !== e.ocol) report("out_col", rsp_tdata[5:3], e.ocol);
            if (rsp_tdata[40:6] !== e.sum) report("product_sum", rsp_tdata[40:6], e.sum);
            if (rsp_tdata[47:41] !== '0) report("pad", rsp_tdata[47:41], 0);
            if (rsp_tlast !== e.lst) report("last", rsp_tlast, e.lst);
            if (typed_pending) begin
               if (rsp_tdata[40:6] !== typed_sum)
                  report("typed sum", rsp_tdata[40:6], typed_sum);
               typed_pending = 0;
            end
         end
      end
   end

   // receiver holds rsp_tready low for a random gap before taking each item
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         gap = $urandom_range(0, 3);
         if (gap != 0) begin
            rsp_tready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // valid stays high after an item until the next send or a drain
   task automatic send(op_type op, logic [2:0] r, logic [2:0] c, logic [15:0] v);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= {v, c, r};
      do @(posedge clock); while (!req_tready);
      predict_item(op, r, c, v);
      @(negedge clock);
   endtask

   task automatic send_raw3();
      int gap;
      gap = $urandom_range(0, 3);
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= OP_NONE;
      req_tdata <= 24'($urandom);
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain(int limit);
      int t = 0;
      req_tvalid <= 0;
      while (pending_elems.size() != 0 && t < limit) begin
         @(negedge clock);
         t++;
      end
      repeat (2*DIM + 4) @(negedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [CFG_W-1:0] v);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ROWS_A: n_rows = v;
         CSR_INNER_SIZE: n_inner = v;
         default: n_cols = v;
      endcase
      @(negedge clock);
   endtask

   task automatic set_shape(logic [CFG_W-1:0] r, logic [CFG_W-1:0] k, logic [CFG_W-1:0] c);
      drain(200000);
      csr_write(CSR_ROWS_A, r);
      csr_write(CSR_INNER_SIZE, k);
      csr_write(CSR_COLS_B, c);
      csr_valid <= 0;
   endtask

   // fill every entry with known or random values
   task automatic load_all(int mode);
      logic [15:0] v;
      for (int r = 0; r < DIM; r++)
         for (int c = 0; c < DIM; c++) begin
            v = (mode == 0) ? 16'(r*DIM + c) : 16'($urandom);
            send(OP_LOAD_A, 3'(r), 3'(c), v);
            send(OP_LOAD_B, 3'(r), 3'(c), mode == 0 ? ~v : 16'($urandom));
         end
   endtask

   initial begin
      vector_type directed[$];
      vector_type t;
      int nr, nk, nc, sent;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // full stores first so that no unwritten entry is ever read
      load_all(0);

      // 1x1x1 run: A[0][0]*B[0][0] = 0x8000 * 0x8000 = 2^30
      set_shape(4'd1, 4'd1, 4'd1);
      // extremes: most negative squared and mixes at corner entries
      t = '{OP_LOAD_A, 0, 0, 16'h8000, 0, '0}; directed.push_back(t);
      t = '{OP_LOAD_B, 0, 0, 16'h8000, 0, '0}; directed.push_back(t);
      t = '{OP_LOAD_A, 7, 7, 16'h7FFF, 0, '0}; directed.push_back(t);
      t = '{OP_LOAD_B, 7, 7, 16'h7FFF, 0, '0}; directed.push_back(t);
      t = '{OP_LOAD_A, 7, 0, 16'hFFFF, 0, '0}; directed.push_back(t);
      t = '{OP_LOAD_B, 0, 7, 16'h0001, 0, '0}; directed.push_back(t);
      t = '{OP_RUN, 3, 5, 16'h1234, 1, 35'h040000000}; directed.push_back(t);
      foreach (directed[i]) begin
         if (directed[i].typed) begin
            typed_pending = 1;
            typed_sum = directed[i].sum;
         end
         send(directed[i].op, directed[i].row, directed[i].col, directed[i].value);
      end
      send_raw3();
      directed.delete();

      // zero shapes act as 1, oversized act as the max
      set_shape(4'd0, 4'd0, 4'd0);
      send(OP_RUN, 3'd0, 3'd0, 16'h0000);
      set_shape(4'd15, 4'd15, 4'd15);
      send(OP_RUN, 3'd7, 3'd7, 16'hFFFF);
      set_shape(4'd8, 4'd1, 4'd2);
      send(OP_RUN, 3'd0, 3'd0, 16'h0000);

      // random phases
      sent = 0;
      while (sent < 150) begin
         nr = $urandom_range(1, DIM);
         nk = $urandom_range(1, DIM);
         nc = $urandom_range(1, DIM);
         if ($urandom_range(0, 5) == 0) nr = 1;
         set_shape(CFG_W'(nr), CFG_W'(nk), CFG_W'(nc));
         repeat ($urandom_range(5, 30)) begin
            case ($urandom_range(0, 9))
               0: send_raw3();
               1, 2, 3, 4: send(OP_LOAD_A, 3'($urandom), 3'($urandom), 16'($urandom));
               5, 6, 7, 8: send(OP_LOAD_B, 3'($urandom), 3'($urandom), 16'($urandom));
               default: send(OP_RUN, 3'($urandom), 3'($urandom), 16'($urandom));
            endcase
            sent++;
         end
         send(OP_RUN, 3'($urandom), 3'($urandom), 16'($urandom));
         sent++;
      end

      drain(200000);
      if (pending_elems.size() != 0) begin
         report("results never arrived", pending_elems.size(), 0);
      end
      $display("covered %0d runs and %0d result elements over several shapes",
               runs_done, elems_seen);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("Some tests failed");
      $finish;
   end

endmodule
